// File: design/fat_volume_layout_calc_core_macros.svh
// assertion macros shared by the fat layout calculator modules
// expects clk and rst_n in the scope of each use
`ifndef FAT_VOLUME_LAYOUT_CALC_CORE_MACROS_SVH
`define FAT_VOLUME_LAYOUT_CALC_CORE_MACROS_SVH

// same-cycle implication
`define FVL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fvl check failed");

// next-cycle implication
`define FVL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fvl check failed");

`endif

// File: design/fvl_pkg.sv
// shared types and constants of the fat layout calculator
// used by the controller, datapath and top level
`timescale 1ns / 1ps

package fvl_pkg;

  localparam int unsigned OUT_W = 232;

  localparam logic [31:0] CAP_RESET     = 32'(30435 * 2048);
  localparam logic [31:0] FAT16_ALIGN   = 32'd128;
  localparam logic [31:0] FAT32_ALIGN   = 32'd8192;
  localparam logic [31:0] FAT16_CL_MIN  = 32'd4085;
  localparam logic [31:0] FAT_CL_LIMIT  = 32'd65525;
  localparam logic [31:0] PT_SMALL_LIM  = 32'd32680;
  localparam logic [31:0] PT_MID_LIM    = 32'd65536;
  localparam logic [32:0] CHS_LIMIT_LBN = 33'd16450560;
  localparam logic [31:0] CYL_MAX       = 32'd1023;
  localparam logic [21:0] MB_HEADS_128  = 22'd4032;

  localparam logic [7:0] PTYPE_FAT12     = 8'h01;
  localparam logic [7:0] PTYPE_FAT16_SM  = 8'h04;
  localparam logic [7:0] PTYPE_FAT16     = 8'h06;
  localparam logic [7:0] PTYPE_FAT32     = 8'h0B;
  localparam logic [7:0] PTYPE_FAT32_LBA = 8'h0C;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_SMALL     = 3'd2,
    ST_FAT16_BAD = 3'd3,
    ST_FAT32_FEW = 3'd4,
    ST_CYL_OVER  = 3'd5
  } status_code_t;

  typedef enum logic [1:0] {
    DIV_BEG_HS,
    DIV_BEG_SPT,
    DIV_END_HS,
    DIV_END_SPT
  } div_sel_t;

  typedef struct packed {
    logic         load;
    logic         classify;
    logic         geom;
    logic         srch_nc;
    logic         srch_fs;
    logic         srch_adv;
    logic         fin1;
    logic         fin2;
    logic         fin3;
    logic         div_start;
    div_sel_t     div_sel;
    logic         publish;
    status_code_t pub_status;
  } dp_cmd_t;

  typedef struct packed {
    logic zero;
    logic small_card;
    logic fat32;
    logic search_done;
    logic nc_bad;
    logic cyl_over;
    logic div_busy;
    logic div_done;
  } dp_stat_t;

endpackage

// File: design/fvl_div.sv
// restoring divider, one quotient bit per cycle
// depends on nothing; used by the datapath for chs arithmetic
`timescale 1ns / 1ps

module fvl_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [13:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quot,
  output logic [13:0] rem
);

  localparam int unsigned DIV_W = 32;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [13:0] rem_r, rem_nxt;
  logic [13:0] dvs_r, dvs_nxt;
  logic [14:0] trial;
  logic [14:0] diff;

  // one trial subtraction a cycle
  always_comb begin
    trial    = {rem_r, quo_r[DIV_W-1]};
    diff     = trial - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[13:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[13:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

// File: design/fvl_dp.sv
// datapath: clamp, geometry, aligned search, layout fields and chs
// depends on fvl_pkg and fvl_div
`timescale 1ns / 1ps

module fvl_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [31:0]             cfg_wr_data,
  input  logic [31:0]             card_blocks,
  input  logic                    high_capacity,
  input  fvl_pkg::dp_cmd_t        cmd,
  output fvl_pkg::dp_stat_t       stat,
  output logic [fvl_pkg::OUT_W-1:0] result
);
  import fvl_pkg::*;

  logic [31:0] cap_r;
  logic [31:0] blocks_r;
  logic        hc_r;
  logic [21:0] mb_r;
  logic [2:0]  sh_r;
  logic [7:0]  heads_r;
  logic [5:0]  spt_r;
  logic [31:0] ds_r, nc_r, fs_r, rel_r, prod_r, psize_r, endl_r;
  logic [15:0] rsv_r;
  logic [7:0]  ptype_r;
  logic [31:0] cb_r, ce_r;
  logic [13:0] rb_r, re_r;
  logic [7:0]  hb_r, he_r;
  logic [5:0]  sb_r, se_r;
  logic [OUT_W-1:0] result_r;

  logic [32:0] mb_sum;
  logic [2:0]  sh_nxt;
  logic [7:0]  heads_nxt;
  logic [31:0] nc_nxt;
  logic [32:0] fs_sum;
  logic [32:0] need;
  logic [13:0] hs;
  logic [31:0] div_a;
  logic [13:0] div_b;
  logic        div_busy, div_done;
  logic [31:0] div_q;
  logic [13:0] div_rm;
  logic [32:0] lim_sum;
  logic [7:0]  spc;
  logic        geo, part, full;
  logic [23:0] chs_b, chs_e;

  // capacity in mb, rounded up
  assign mb_sum = {1'b0, blocks_r} + 33'd2047;

  // cluster size and head count by capacity
  always_comb begin
    if (mb_r <= 22'd16)         sh_nxt = 3'd1;
    else if (mb_r <= 22'd32)    sh_nxt = 3'd2;
    else if (mb_r <= 22'd64)    sh_nxt = 3'd3;
    else if (mb_r <= 22'd128)   sh_nxt = 3'd4;
    else if (mb_r <= 22'd1024)  sh_nxt = 3'd5;
    else if (mb_r <= 22'd32768) sh_nxt = 3'd6;
    else                        sh_nxt = 3'd7;
    if (mb_r <= 22'd16)               heads_nxt = 8'd2;
    else if (mb_r <= 22'd32)          heads_nxt = 8'd4;
    else if (mb_r <= 22'd128)         heads_nxt = 8'd8;
    else if (mb_r <= 22'd504)         heads_nxt = 8'd16;
    else if (mb_r <= 22'd1008)        heads_nxt = 8'd32;
    else if (mb_r <= 22'd2016)        heads_nxt = 8'd64;
    else if (mb_r <= MB_HEADS_128)    heads_nxt = 8'd128;
    else                              heads_nxt = 8'd255;
  end

  // search terms: cluster count, fat size, data start bound
  assign nc_nxt = (blocks_r <= ds_r) ? 32'd0 : ((blocks_r - ds_r) >> sh_r);
  assign fs_sum = hc_r ? (({1'b0, nc_r} + 33'd129) >> 7) : (({1'b0, nc_r} + 33'd257) >> 8);
  assign need   = hc_r ? ({1'b0, FAT32_ALIGN} + 33'd9 + {fs_r, 1'b0})
                       : (33'd161 + {fs_r, 1'b0});

  // divider operand selection
  assign hs = 14'(heads_r * spt_r);
  always_comb begin
    case (cmd.div_sel)
      DIV_BEG_HS: begin
        div_a = rel_r;
        div_b = hs;
      end
      DIV_BEG_SPT: begin
        div_a = {18'd0, rb_r};
        div_b = {8'd0, spt_r};
      end
      DIV_END_HS: begin
        div_a = endl_r;
        div_b = hs;
      end
      DIV_END_SPT: begin
        div_a = {18'd0, re_r};
        div_b = {8'd0, spt_r};
      end
      default: begin
        div_a = rel_r;
        div_b = hs;
      end
    endcase
  end

  fvl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rm)
  );

  assign lim_sum = {1'b0, rel_r} + {1'b0, psize_r};

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      blocks_r <= (card_blocks > cap_r) ? cap_r : card_blocks;
      hc_r     <= high_capacity;
    end
    if (cmd.classify) begin
      mb_r <= mb_sum[32:11];
    end
    if (cmd.geom) begin
      sh_r    <= sh_nxt;
      heads_r <= heads_nxt;
      spt_r   <= (mb_r <= 22'd256) ? 6'd32 : 6'd63;
      ds_r    <= hc_r ? {FAT32_ALIGN[30:0], 1'b0} : {FAT16_ALIGN[30:0], 1'b0};
    end
    if (cmd.srch_nc) begin
      nc_r <= nc_nxt;
    end
    if (cmd.srch_fs) begin
      fs_r <= fs_sum[31:0];
    end
    if (cmd.srch_adv) begin
      ds_r <= ds_r + (hc_r ? FAT32_ALIGN : FAT16_ALIGN);
    end
    if (cmd.fin1) begin
      rel_r  <= hc_r ? FAT32_ALIGN : (ds_r - {fs_r[30:0], 1'b0} - 32'd33);
      rsv_r  <= hc_r ? 16'(ds_r - FAT32_ALIGN - {fs_r[30:0], 1'b0}) : 16'd1;
      prod_r <= nc_r << sh_r;
    end
    if (cmd.fin2) begin
      psize_r <= hc_r ? (prod_r + ds_r - FAT32_ALIGN)
                      : (prod_r + {fs_r[30:0], 1'b0} + 32'd33);
    end
    if (cmd.fin3) begin
      endl_r <= rel_r + psize_r - 32'd1;
      if (hc_r)                       ptype_r <= (lim_sum <= CHS_LIMIT_LBN) ? PTYPE_FAT32
                                                                         : PTYPE_FAT32_LBA;
      else if (psize_r < PT_SMALL_LIM) ptype_r <= PTYPE_FAT12;
      else if (psize_r < PT_MID_LIM)   ptype_r <= PTYPE_FAT16_SM;
      else                             ptype_r <= PTYPE_FAT16;
    end
    // capture divider results
    if (div_done) begin
      case (cmd.div_sel)
        DIV_BEG_HS: begin
          cb_r <= div_q;
          rb_r <= div_rm;
        end
        DIV_BEG_SPT: begin
          hb_r <= div_q[7:0];
          sb_r <= div_rm[5:0] + 6'd1;
        end
        DIV_END_HS: begin
          ce_r <= div_q;
          re_r <= div_rm;
        end
        DIV_END_SPT: begin
          he_r <= div_q[7:0];
          se_r <= div_rm[5:0] + 6'd1;
        end
        default: begin
          cb_r <= div_q;
          rb_r <= div_rm;
        end
      endcase
    end
    if (cmd.publish) begin
      result_r <= {7'd0,
                   full ? chs_e : 24'd0,
                   full ? chs_b : 24'd0,
                   geo ? ds_r : 32'd0,
                   geo ? fs_r : 32'd0,
                   part ? rsv_r : 16'd0,
                   part ? ptype_r : 8'd0,
                   part ? psize_r : 32'd0,
                   geo ? rel_r : 32'd0,
                   geo ? spt_r : 6'd0,
                   geo ? heads_r : 8'd0,
                   geo ? spc : 8'd0,
                   cmd.pub_status};
    end
  end

  // field masking by outcome
  assign spc   = 8'd1 << sh_r;
  assign geo   = (cmd.pub_status != ST_ZERO) && (cmd.pub_status != ST_SMALL);
  assign part  = (cmd.pub_status == ST_OK) || (cmd.pub_status == ST_CYL_OVER);
  assign full  = (cmd.pub_status == ST_OK);
  assign chs_b = {cb_r[9:0], hb_r, sb_r};
  assign chs_e = (ce_r > CYL_MAX) ? {CYL_MAX[9:0], 8'd254, 6'd63} : {ce_r[9:0], he_r, se_r};

  // status toward the controller
  always_comb begin
    stat.zero        = (blocks_r == 32'd0);
    stat.small_card  = (mb_r <= 22'd6);
    stat.fat32       = hc_r;
    stat.search_done = ({1'b0, ds_r} >= need);
    stat.nc_bad      = hc_r ? (nc_r < FAT_CL_LIMIT)
                            : ((nc_r < FAT16_CL_MIN) || (nc_r >= FAT_CL_LIMIT));
    stat.cyl_over    = (cb_r > CYL_MAX);
    stat.div_busy    = div_busy;
    stat.div_done    = div_done;
  end

  assign result = result_r;

endmodule

// File: design/fvl_ctrl.sv
// controller: sequences load, search, layout steps, divisions and output
// depends on fvl_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "fat_volume_layout_calc_core_macros.svh"

module fvl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  fvl_pkg::dp_stat_t stat,
  output fvl_pkg::dp_cmd_t  cmd
);
  import fvl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLASS, S_GEOM, S_SRCH_NC, S_SRCH_FS, S_SRCH_CHK,
    S_FIN1, S_FIN2, S_FIN3, S_DIV_GO, S_DIV_WAIT, S_PUB
  } state_t;

  state_t       state_r, state_nxt;
  div_sel_t     sel_r, sel_nxt;
  status_code_t pub_r, pub_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         slot_free;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    sel_nxt        = sel_r;
    pub_nxt        = pub_r;
    cmd            = '0;
    cmd.div_sel    = sel_r;
    cmd.pub_status = pub_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        state_nxt    = S_GEOM;
      end
      S_GEOM: begin
        cmd.geom = 1'b1;
        if (stat.zero) begin
          pub_nxt   = ST_ZERO;
          state_nxt = S_PUB;
        end else if (stat.small_card) begin
          pub_nxt   = ST_SMALL;
          state_nxt = S_PUB;
        end else begin
          state_nxt = S_SRCH_NC;
        end
      end
      S_SRCH_NC: begin
        cmd.srch_nc = 1'b1;
        state_nxt   = S_SRCH_FS;
      end
      S_SRCH_FS: begin
        cmd.srch_fs = 1'b1;
        state_nxt   = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (stat.search_done) begin
          state_nxt = S_FIN1;
        end else begin
          cmd.srch_adv = 1'b1;
          state_nxt    = S_SRCH_NC;
        end
      end
      S_FIN1: begin
        cmd.fin1  = 1'b1;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        cmd.fin2  = 1'b1;
        state_nxt = S_FIN3;
      end
      S_FIN3: begin
        cmd.fin3 = 1'b1;
        if (stat.nc_bad) begin
          pub_nxt   = stat.fat32 ? ST_FAT32_FEW : ST_FAT16_BAD;
          state_nxt = S_PUB;
        end else begin
          sel_nxt   = DIV_BEG_HS;
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          case (sel_r)
            DIV_BEG_HS: begin
              sel_nxt   = DIV_BEG_SPT;
              state_nxt = S_DIV_GO;
            end
            DIV_BEG_SPT: begin
              if (stat.cyl_over) begin
                pub_nxt   = ST_CYL_OVER;
                state_nxt = S_PUB;
              end else begin
                sel_nxt   = DIV_END_HS;
                state_nxt = S_DIV_GO;
              end
            end
            DIV_END_HS: begin
              sel_nxt   = DIV_END_SPT;
              state_nxt = S_DIV_GO;
            end
            DIV_END_SPT: begin
              pub_nxt   = ST_OK;
              state_nxt = S_PUB;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_PUB: begin
        if (slot_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // output slot: set on publish, cleared on transfer
    if (cmd.publish)      out_valid_nxt = 1'b1;
    else if (out_tready)  out_valid_nxt = 1'b0;
    else                  out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= DIV_BEG_HS;
      pub_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      pub_r       <= pub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `FVL_ASSERT_IMPL(a_pub_slot, cmd.publish, !out_valid_r || out_tready)
  `FVL_ASSERT_IMPL(a_div_idle, cmd.div_start, !stat.div_busy)
  `FVL_ASSERT_NEXT(a_load_class, in_tvalid && in_tready, state_r == S_CLASS)
  `FVL_ASSERT_IMPL(a_done_wait, stat.div_done, state_r == S_DIV_WAIT)

endmodule

// File: design/fat_volume_layout_calc_core.sv
// FAT layout calculator for SD cards: one input transfer (block count and a
// high-capacity flag) gives one result transfer with status, cluster size,
// fake geometry, partition fields, FAT size, data start and packed CHS.
// Items are handled one at a time. An item runs the load and layout steps and
// the aligned data start search (up to about 2000 steps for a very large card
// in FAT16 mode, a few dozen in FAT32 mode), plus up to four divisions on the
// one shared bit-serial divider that forms the CHS values. A finished result
// waits in an output register, and a new item is taken while it waits.
// block_cap is to be written via cfg_wr_en only while idle; the block does not enforce this.
// Depends on fvl_pkg, fvl_ctrl, fvl_dp and fvl_div.
`timescale 1ns / 1ps

module fat_volume_layout_calc_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [31:0]               cfg_wr_data,   // block_cap
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [31:0]               in_tdata,      // card_blocks[31:0]
  input  logic                      in_tuser,      // high_capacity
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // status[2:0], sectors_per_cluster[10:3], head_count[18:11],
  // sectors_per_track[24:19], partition_start[56:25], partition_size[88:57],
  // partition_type[96:89], reserved_sectors[112:97], fat_sectors[144:113],
  // data_start[176:145], chs_begin[200:177], chs_end[224:201], zero pad above
  output logic [fvl_pkg::OUT_W-1:0] out_tdata
);
  import fvl_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing
  fvl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // arithmetic and result register
  fvl_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .card_blocks   (in_tdata),
    .high_capacity (in_tuser),
    .cmd           (cmd),
    .stat          (stat),
    .result        (out_tdata)
  );

endmodule

// File: dv/fvl_layout_checker.sv
// checker for the fat layout calculator: watches both streams and the cap write,
// computes each expected layout and compares it field by field
// depends on fvl_pkg
`timescale 1ns / 1ps

module fvl_layout_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [31:0]               cfg_wr_data,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [31:0]               in_tdata,
  input  logic                      in_tuser,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [fvl_pkg::OUT_W-1:0] out_tdata,
  output int                        fail_count,
  output int                        pending_count
);
  import fvl_pkg::*;

  typedef struct packed {
    logic [23:0] chs_end;
    logic [23:0] chs_begin;
    logic [31:0] data_start;
    logic [31:0] fat_sectors;
    logic [15:0] reserved_sectors;
    logic [7:0]  partition_type;
    logic [31:0] partition_size;
    logic [31:0] partition_start;
    logic [5:0]  sectors_per_track;
    logic [7:0]  head_count;
    logic [7:0]  sectors_per_cluster;
    logic [2:0]  status;
  } layout_t;

  logic [31:0] cap_q;
  layout_t     expected_layouts[$];

  function automatic logic [23:0] pack_chs(logic [63:0] c, logic [63:0] h, logic [63:0] s);
    return {c[9:0], h[7:0], s[5:0]};
  endfunction

  function automatic logic [31:0] clusters_left(logic [31:0] blocks, logic [31:0] start,
                                                logic [31:0] spc);
    if (blocks <= start) return 0;
    return (blocks - start) / spc;
  endfunction

  // layout for one block count under the current cap
  function automatic layout_t calc_layout(logic [31:0] card_blocks, logic hc);
    layout_t r;
    logic [31:0] blocks, spc, heads, spt, nc;
    logic [63:0] mb, ds, fs, rel, psize, rsv, lim, hs, c, endl;
    r = '0;
    psize = 0;
    rsv = 0;
    blocks = (card_blocks > cap_q) ? cap_q : card_blocks;
    if (blocks == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    mb = (64'(blocks) + 2047) / 2048;
    if (mb <= 6) begin
      r.status = ST_SMALL;
      return r;
    end
    if (mb <= 16) spc = 2;
    else if (mb <= 32) spc = 4;
    else if (mb <= 64) spc = 8;
    else if (mb <= 128) spc = 16;
    else if (mb <= 1024) spc = 32;
    else if (mb <= 32768) spc = 64;
    else spc = 128;
    spt = (mb <= 256) ? 32 : 63;
    if (mb <= 16) heads = 2;
    else if (mb <= 32) heads = 4;
    else if (mb <= 128) heads = 8;
    else if (mb <= 504) heads = 16;
    else if (mb <= 1008) heads = 32;
    else if (mb <= 2016) heads = 64;
    else if (mb <= 4032) heads = 128;
    else heads = 255;
    r.sectors_per_cluster = spc[7:0];
    r.head_count = heads[7:0];
    r.sectors_per_track = spt[5:0];
    if (!hc) begin
      // fat16: grow the data start until the fats fit in front of it
      ds = 2 * 64'(FAT16_ALIGN);
      forever begin
        nc = clusters_left(blocks, ds[31:0], spc);
        fs = (64'(nc) + 257) / 256;
        lim = 64'(FAT16_ALIGN) + 33 + 2 * fs;
        if (ds >= lim) break;
        ds += 64'(FAT16_ALIGN);
      end
      rel = ds - lim + 64'(FAT16_ALIGN);
      r.partition_start = rel[31:0];
      r.fat_sectors = fs[31:0];
      r.data_start = ds[31:0];
      if (nc < FAT16_CL_MIN || nc >= FAT_CL_LIMIT) begin
        r.status = ST_FAT16_BAD;
        return r;
      end
      rsv = 1;
      psize = 64'(nc) * spc + 2 * fs + rsv + 32;
      if (psize < 64'(PT_SMALL_LIM)) r.partition_type = PTYPE_FAT12;
      else if (psize < 64'(PT_MID_LIM)) r.partition_type = PTYPE_FAT16_SM;
      else r.partition_type = PTYPE_FAT16;
    end else begin
      // fat32: same search on coarser steps
      rel = 64'(FAT32_ALIGN);
      ds = 2 * 64'(FAT32_ALIGN);
      forever begin
        nc = clusters_left(blocks, ds[31:0], spc);
        fs = (64'(nc) + 129) / 128;
        if (ds >= rel + 9 + 2 * fs) break;
        ds += 64'(FAT32_ALIGN);
      end
      r.partition_start = rel[31:0];
      r.fat_sectors = fs[31:0];
      r.data_start = ds[31:0];
      if (nc < FAT_CL_LIMIT) begin
        r.status = ST_FAT32_FEW;
        return r;
      end
      rsv = ds - rel - 2 * fs;
      psize = 64'(nc) * spc + ds - rel;
      r.partition_type = (rel + psize <= 64'(CHS_LIMIT_LBN)) ? PTYPE_FAT32 : PTYPE_FAT32_LBA;
    end
    psize = psize & 64'hFFFF_FFFF;
    r.partition_size = psize[31:0];
    r.reserved_sectors = rsv[15:0];
    // chs of first and last block
    hs = 64'(heads) * spt;
    c = rel / hs;
    if (c > 64'(CYL_MAX)) begin
      r.status = ST_CYL_OVER;
      return r;
    end
    r.chs_begin = pack_chs(c, (rel % hs) / spt, rel % spt + 1);
    endl = (rel + psize - 1) & 64'hFFFF_FFFF;
    c = endl / hs;
    if (c <= 64'(CYL_MAX)) r.chs_end = pack_chs(c, (endl % hs) / spt, endl % spt + 1);
    else r.chs_end = pack_chs(64'(CYL_MAX), 254, 63);
    r.status = ST_OK;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending_count = expected_layouts.size();

  // track cap, queue predictions, compare results
  always @(posedge clk) begin
    layout_t e, a;
    if (!rst_n) begin
      cap_q <= CAP_RESET;
      expected_layouts.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) cap_q <= cfg_wr_data;
      if (in_tvalid && in_tready) expected_layouts.push_back(calc_layout(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        a = layout_t'(out_tdata[224:0]);
        if (expected_layouts.size() == 0) begin
          $error("result transfer with no expected layout");
          fail_count++;
        end else begin
          e = expected_layouts.pop_front();
          check_field("status", e.status, a.status);
          check_field("sectors_per_cluster", e.sectors_per_cluster, a.sectors_per_cluster);
          check_field("head_count", e.head_count, a.head_count);
          check_field("sectors_per_track", e.sectors_per_track, a.sectors_per_track);
          check_field("partition_start", e.partition_start, a.partition_start);
          check_field("partition_size", e.partition_size, a.partition_size);
          check_field("partition_type", e.partition_type, a.partition_type);
          check_field("reserved_sectors", e.reserved_sectors, a.reserved_sectors);
          check_field("fat_sectors", e.fat_sectors, a.fat_sectors);
          check_field("data_start", e.data_start, a.data_start);
          check_field("chs_begin", e.chs_begin, a.chs_begin);
          check_field("chs_end", e.chs_end, a.chs_end);
          check_field("pad", 32'd0, 32'(out_tdata[fvl_pkg::OUT_W-1:225]));
        end
      end
    end
  end
endmodule

// File: dv/tb_fat_volume_layout_calc_core.sv
// stimulus top for the fat layout calculator: drives cap writes and card sizes
// in several phases with random idling; verdict from fvl_layout_checker
// depends on fvl_pkg, fat_volume_layout_calc_core and fvl_layout_checker
`timescale 1ns / 1ps

module tb_fat_volume_layout_calc_core;
  import fvl_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [31:0]         cfg_wr_data = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [31:0]         in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;
  int                  fail_count;
  int                  pending_count;
  bit                  calm_mode = 1'b0;
  bit                  hold_sink = 1'b0;
  int                  quiet_cycles = 0;

  localparam int QUIET_LIMIT = 400000;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  fat_volume_layout_calc_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  fvl_layout_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  // receiver: random stalls, or a long hold when asked
  always @(negedge clk) begin
    if (!rst_n || hold_sink) out_tready <= 1'b0;
    else out_tready <= calm_mode || ($urandom_range(99) >= 22);
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // valid drops only in idle gaps; ready moves at the rising edge, so it is
  // stable at the falling edge and decides the transfer at the next one
  task automatic send_card(logic [31:0] blocks, logic hc);
    while (!calm_mode && $urandom_range(99) < 22) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= blocks;
    in_tuser  <= hc;
    while (!in_tready) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_cap(logic [31:0] v);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly small cards to keep fat16 searches short, some large ones
  function automatic logic [31:0] rand_blocks();
    case ($urandom_range(9))
      0:       return $urandom_range(16384);
      1, 2:    return $urandom_range(300000, 12000);
      3, 4:    return $urandom_range(4200000, 300000);
      5:       return $urandom_range(70000000, 4000000);
      6:       return $urandom;
      7:       return {2'($urandom_range(3)), 30'($urandom)};
      default: return $urandom_range(2200000, 8000);
    endcase
  endfunction

  initial begin
    logic [31:0] caps[4];
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero, small edge, fat16/fat32 boundaries, cap clamp, huge
    send_card(32'd0, 1'b0);
    send_card(32'd12288, 1'b0);
    send_card(32'd12289, 1'b0);
    send_card(32'd16000, 1'b1);
    send_card(32'd32768, 1'b0);
    send_card(32'd65536, 1'b0);
    send_card(32'd131072, 1'b0);
    send_card(32'd262144, 1'b0);
    send_card(32'd524288, 1'b0);
    send_card(32'd2097152, 1'b0);
    send_card(32'd4194304, 1'b0);
    send_card(32'd8257536, 1'b1);
    send_card(32'd16450560, 1'b1);
    send_card(32'd1000000, 1'b1);
    send_card(32'd62330880, 1'b1);
    send_card(32'hFFFF_FFFF, 1'b1);
    send_card(32'hFFFF_FFFF, 1'b0);

    // extreme caps: max, zero and one
    write_cap(32'hFFFF_FFFF);
    send_card(32'hFFFF_FFFF, 1'b1);
    send_card(32'h8000_0000, 1'b1);
    send_card(32'd100000000, 1'b1);
    write_cap(32'd0);
    send_card(32'd5000000, 1'b1);
    send_card(32'd5000000, 1'b0);
    write_cap(32'd1);
    send_card(32'd5000000, 1'b0);
    send_card(32'd1, 1'b1);

    // random phases at various caps
    caps[0] = 32'd62330880;
    caps[1] = 32'd4194304;
    caps[2] = 32'hFFFF_FFFF;
    caps[3] = 32'd20000000;
    for (int p = 0; p < 4; p++) begin
      write_cap(caps[p]);
      calm_mode = (p == 1);
      if (p == 2) begin
        // receiver holds off while the sender keeps offering
        fork
          begin
            hold_sink = 1'b1;
            repeat (3000) @(negedge clk);
            hold_sink = 1'b0;
          end
          for (int i = 0; i < 8; i++) send_card(rand_blocks(), 1'($urandom));
        join
      end
      for (int i = 0; i < 205; i++) begin
        send_card(rand_blocks(), 1'($urandom));
        if (i == 100) drain_results();
      end
    end
    calm_mode = 1'b0;

    drain_results();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
